@@ rtl/core/sih_pkg.sv @@
// shared types and constants for the stream id hash table
// no dependencies; used by sih_slot_mem, sih_ctrl and stream_id_hash_table
package sih_pkg;

    localparam int TABLE_SIZE = 64;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 32;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = 7;
    localparam int OUT_W      = 24;

    localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(64);

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_TOMB  = 2'd1,
        TAG_USED  = 2'd2
    } tag_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_FIND   = 3'd1,
        CMD_EXISTS = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_CLOSE  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_ABSENT = 3'd1,
        ST_LIMIT  = 3'd2,
        ST_DUP    = 3'd3,
        ST_NOSLOT = 3'd4
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        tag_t             tag;
        logic             closed;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic              closed;
        logic [CNT_W-1:0]  count;
    } result_t;

endpackage

@@ rtl/core/sih_slot_mem.sv @@
// slot memory: key, tag and closed flag per slot, one write and one registered read
// per-slot valid flops make never-written slots read as empty; depends on sih_pkg
module sih_slot_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  sih_pkg::mem_req_t req,
    output sih_pkg::entry_t   rd_entry
);

    sih_pkg::entry_t                  slot_mem [sih_pkg::TABLE_SIZE];
    sih_pkg::entry_t                  rd_data_reg;
    logic [sih_pkg::TABLE_SIZE-1:0]   valid_reg;
    logic                             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            slot_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= slot_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_entry = rd_data_reg;
        if (!rd_valid_reg)
        begin
            rd_entry.tag    = sih_pkg::TAG_EMPTY;
            rd_entry.closed = 1'b0;
        end
    end

endmodule

@@ rtl/core/sih_ctrl.sv @@
// probe sequencer: walks the probe path one slot per read, one key compare per step
// keeps the live entry count; depends on sih_pkg, drives sih_slot_mem
module sih_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sih_pkg::cmd_t                 cmd,
    input  logic [sih_pkg::KEY_W-1:0]     id,
    input  logic [sih_pkg::CNT_W-1:0]     limit,
    input  logic                          res_ack,
    input  sih_pkg::entry_t               rd_entry,
    output logic                          idle,
    output logic                          res_valid,
    output sih_pkg::result_t              result,
    output sih_pkg::mem_req_t             mem_req
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    sih_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [sih_pkg::KEY_W-1:0]       id_reg, id_next;
    logic [sih_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [sih_pkg::SLOT_W-1:0]      probe_reg, probe_next;
    logic                            free_found_reg, free_found_next;
    logic [sih_pkg::SLOT_W-1:0]      free_slot_reg, free_slot_next;
    logic [sih_pkg::CNT_W-1:0]       live_reg, live_next;
    sih_pkg::result_t                res_reg, res_next;

    logic                            hit;
    logic                            free_here;
    logic                            free_ok;
    logic [sih_pkg::SLOT_W-1:0]      free_at;

    assign hit       = (rd_entry.tag == sih_pkg::TAG_USED) && (rd_entry.key == id_reg);
    assign free_here = (rd_entry.tag != sih_pkg::TAG_USED);
    assign free_ok   = free_found_reg || free_here;
    assign free_at   = free_found_reg ? free_slot_reg : slot_reg;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign result    = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        live_next       = live_reg;
        res_next        = res_reg;
        mem_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    id_next         = id;
                    slot_next       = id[sih_pkg::SLOT_W-1:0];
                    probe_next      = '0;
                    free_found_next = 1'b0;
                    res_next        = '{status: sih_pkg::ST_ABSENT, slot: '0,
                                        closed: 1'b0, count: live_reg};
                    case (cmd)
                        sih_pkg::CMD_CREATE:
                        begin
                            if (live_reg >= limit)
                            begin
                                res_next.status = sih_pkg::ST_LIMIT;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        sih_pkg::CMD_FIND,
                        sih_pkg::CMD_EXISTS,
                        sih_pkg::CMD_REMOVE,
                        sih_pkg::CMD_CLOSE:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = slot_reg;
                state_next      = S_CHECK;
            end

            S_CHECK:
            begin
                mem_req.wr_addr = slot_reg;
                mem_req.wr_data = '{key: id_reg, tag: sih_pkg::TAG_USED, closed: 1'b0};
                if (hit)
                begin
                    state_next = S_DONE;
                    case (cmd_reg)
                        sih_pkg::CMD_CREATE:
                        begin
                            res_next.status = sih_pkg::ST_DUP;
                        end
                        sih_pkg::CMD_FIND:
                        begin
                            if (!rd_entry.closed)
                            begin
                                res_next.status = sih_pkg::ST_OK;
                                res_next.slot   = slot_reg;
                            end
                        end
                        sih_pkg::CMD_EXISTS:
                        begin
                            res_next.status = sih_pkg::ST_OK;
                            res_next.slot   = slot_reg;
                            res_next.closed = rd_entry.closed;
                        end
                        sih_pkg::CMD_REMOVE:
                        begin
                            mem_req.wr_en       = 1'b1;
                            mem_req.wr_data.tag = sih_pkg::TAG_TOMB;
                            res_next.status     = sih_pkg::ST_OK;
                            res_next.slot       = slot_reg;
                            res_next.closed     = rd_entry.closed;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                            res_next.count = (live_reg != '0) ? live_reg - 1'b1 : live_reg;
                        end
                        sih_pkg::CMD_CLOSE:
                        begin
                            mem_req.wr_en          = 1'b1;
                            mem_req.wr_data.closed = 1'b1;
                            res_next.status        = sih_pkg::ST_OK;
                            res_next.slot          = slot_reg;
                            res_next.closed        = 1'b1;
                        end
                        default:
                        begin
                            res_next.status = sih_pkg::ST_ABSENT;
                        end
                    endcase
                end
                else if ((rd_entry.tag == sih_pkg::TAG_EMPTY) || (probe_reg == sih_pkg::SLOT_LAST))
                begin
                    state_next = S_DONE;
                    if (cmd_reg == sih_pkg::CMD_CREATE)
                    begin
                        if (free_ok)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = free_at;
                            live_next       = live_reg + 1'b1;
                            res_next.status = sih_pkg::ST_OK;
                            res_next.slot   = free_at;
                            res_next.count  = live_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = sih_pkg::ST_NOSLOT;
                        end
                    end
                end
                else
                begin
                    if (free_here && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = slot_reg;
                    end
                    probe_next = probe_reg + 1'b1;
                    slot_next  = (slot_reg == sih_pkg::SLOT_LAST) ? '0 : slot_reg + 1'b1;
                    state_next = S_READ;
                end
            end

            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        slot_reg       <= slot_next;
        probe_reg      <= probe_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        res_reg        <= res_next;
    end

endmodule

@@ rtl/core/stream_id_hash_table.sv @@
// Stream ID table with open addressing and linear probing over 64 slots. A command
// beat carries the command in tuser and the 32-bit id in tdata and gets exactly one
// result beat. The home slot is the low six bits of the id. The slot memory has one
// read port with a registered read, so each probed slot takes a read state and a
// check state in turn; create over the limit and unknown commands skip the probe.
// The next command is taken once the current one has handed its result to the
// output register; the output register holds a result while the sink stalls. The
// stream limit may only be written while the block is idle; it resets to 64.
module stream_id_hash_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sih_pkg::CNT_W-1:0]        cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sih_pkg::KEY_W-1:0]        s_axis_tdata,  // stream_id
    input  logic [sih_pkg::CMD_W-1:0]        s_axis_tuser,  // cmd
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sih_pkg::OUT_W-1:0]        m_axis_tdata   // status, slot_index, is_closed, active_count
);

    logic [sih_pkg::CNT_W-1:0]   limit_reg;
    logic                        m_valid_reg;
    sih_pkg::result_t            m_res_reg;

    logic                        idle;
    logic                        res_valid;
    logic                        res_load;
    sih_pkg::result_t            result;
    sih_pkg::mem_req_t           mem_req;
    sih_pkg::entry_t             rd_entry;

    assign s_axis_tready = idle;
    assign res_load      = res_valid && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(sih_pkg::OUT_W - $bits(sih_pkg::result_t)){1'b0}},
                            m_res_reg.count, m_res_reg.closed, m_res_reg.slot,
                            m_res_reg.status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= sih_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (res_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_res_reg <= result;
        end
    end

    sih_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && idle),
        .cmd       (sih_pkg::cmd_t'(s_axis_tuser)),
        .id        (s_axis_tdata),
        .limit     (limit_reg),
        .res_ack   (res_load),
        .rd_entry  (rd_entry),
        .idle      (idle),
        .res_valid (res_valid),
        .result    (result),
        .mem_req   (mem_req)
    );

    sih_slot_mem u_slot_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

endmodule
